>>> src/bblur_pkg.sv
// Shared types, widths and constants for the 3x3 edge-normalised box blur.
// No dependencies; every other file of the block refers to this package.
package bblur_pkg;

  localparam int PIX_W       = 8;
  localparam int CFG_W_W     = 9;
  localparam int CFG_H_W     = 13;
  localparam int ROW_W       = 12;
  localparam int MAX_WIDTH_DEF = 256;
  localparam int MAX_HEIGHT  = 4096;
  localparam int RESET_WIDTH = 160;
  localparam int RESET_HEIGHT = 160;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;
  localparam int COLSUM_W    = 10;
  localparam int SUM_W       = 12;
  localparam int CNT_W       = 4;
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = SUM_W + RECIP_W;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_PUSH2,
    S_COL,
    S_TOT,
    S_MUL,
    S_EMIT
  } state_t;

  // ceil(2^16 / n) for every neighbour count; exact for sums below 2^15
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] m;
    case (cnt)
      CNT_W'(1): m = RECIP_W'(65536);
      CNT_W'(2): m = RECIP_W'(32768);
      CNT_W'(3): m = RECIP_W'(21846);
      CNT_W'(4): m = RECIP_W'(16384);
      CNT_W'(6): m = RECIP_W'(10923);
      CNT_W'(9): m = RECIP_W'(7282);
      default:   m = RECIP_W'(65536);
    endcase
    return m;
  endfunction

endpackage

>>> src/bblur_if.sv
// Valid/ready stream interfaces for the pixel input and the blurred output.
// Depends on bblur_pkg for the pixel width.
interface bblur_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [bblur_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, command, pixel_in, input ready);
  modport sink   (input valid, command, pixel_in, output ready);
endinterface

interface bblur_out_if;
  logic                        valid;
  logic                        ready;
  logic [bblur_pkg::PIX_W-1:0] pixel_out;
  logic                        end_of_frame;
  logic                        dropped;

  modport source (output valid, pixel_out, end_of_frame, dropped, input ready);
  modport sink   (input valid, pixel_out, end_of_frame, dropped, output ready);
endinterface

>>> src/box_blur_3x3_edge_normalized.sv
// 3x3 box blur, edge-normalised mean, one line memory holding two rows per entry.
// Read / modify / write on the line memory, then sum, reciprocal multiply and output
// load. An item with no result ends after the write; the last pixel of a one-row
// frame first pushes one more empty column, and a dropped pixel skips the arithmetic.
// One item at a time, taken only once the last is through, output stall included.
// Synchronous active-low reset, memory not cleared. Depends on bblur_pkg and bblur_if.
module box_blur_3x3_edge_normalized #(
  parameter int MAX_WIDTH = bblur_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bblur_in_if.sink                       in_ch,
  bblur_out_if.source                    out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bblur_pkg::APB_AW-1:0]   paddr,
  input  logic [bblur_pkg::APB_DW-1:0]   pwdata,
  output logic [bblur_pkg::APB_DW-1:0]   prdata,
  output logic                           pready
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int EWA = $clog2(MAX_WIDTH + 1);
  localparam int EWW = (bblur_pkg::CFG_W_W > EWA) ? bblur_pkg::CFG_W_W : EWA;
  localparam int PW  = bblur_pkg::PIX_W;
  localparam int HW  = bblur_pkg::CFG_H_W;
  localparam int RW  = bblur_pkg::ROW_W;

  // configuration
  logic [bblur_pkg::CFG_W_W-1:0] width_r;
  logic [HW-1:0]                 height_r;
  logic                          cfg_we;
  logic [EWW-1:0]                eff_w;
  logic [HW-1:0]                 eff_h;

  // sequencer and stream position
  bblur_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]     in_col_r;
  logic [RW-1:0]     in_row_r;
  logic [CW-1:0]     out_col_r;
  logic [RW-1:0]     out_row_r;
  logic              draining_r;
  logic              extra_r;
  logic              pend_r;
  logic              drop_r;
  logic [3*PW-1:0]   win_r [3];

  // item and arithmetic registers
  logic                           cmd_r;
  logic [PW-1:0]                  px_r;
  logic [bblur_pkg::COLSUM_W-1:0] colsum_r [3];
  logic [bblur_pkg::COLSUM_W-1:0] colsum   [3];
  logic [bblur_pkg::CNT_W-1:0]    cnt_r;
  logic [bblur_pkg::CNT_W-1:0]    cnt;
  logic [bblur_pkg::SUM_W-1:0]    sum_r;
  logic [bblur_pkg::RECIP_W-1:0]  recip_r;
  logic [bblur_pkg::PROD_W-1:0]   prod_r;

  // line memory: {row above, current row} per column
  logic [2*PW-1:0] line_mem [MAX_WIDTH];
  logic [2*PW-1:0] rd_q;
  logic [PW-1:0]   rd_above;
  logic [PW-1:0]   rd_cur;
  logic [PW-1:0]   push_px;

  // output register
  logic          out_valid_r;
  logic [PW-1:0] out_pix_r;
  logic          out_eof_r;
  logic          out_drop_r;

  // control
  logic accept, in_ready, mem_re, do_push, pix_adv;
  logic ld_col, ld_tot, ld_mul, emit_fire, out_free, restart;
  logic in_col_last, in_row_last, ready_in, h_one, out_col_last, out_row_last, out_last;
  logic rd_idle, rd_drop, rd_flush, rd_pix, last_one_row;
  logic [CW-1:0] in_col_next;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    case (bblur_pkg::reg_idx_t'(paddr[2]))
      bblur_pkg::REG_WIDTH:  prdata = bblur_pkg::APB_DW'(width_r);
      bblur_pkg::REG_HEIGHT: prdata = bblur_pkg::APB_DW'(height_r);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bblur_pkg::CFG_W_W'(bblur_pkg::RESET_WIDTH);
      height_r <= HW'(bblur_pkg::RESET_HEIGHT);
    end else if (cfg_we) begin
      case (bblur_pkg::reg_idx_t'(paddr[2]))
        bblur_pkg::REG_WIDTH:  width_r  <= pwdata[bblur_pkg::CFG_W_W-1:0];
        bblur_pkg::REG_HEIGHT: height_r <= pwdata[HW-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (width_r == '0) begin
      eff_w = EWW'(1);
    end else if (EWW'(width_r) > EWW'(MAX_WIDTH)) begin
      eff_w = EWW'(MAX_WIDTH);
    end else begin
      eff_w = EWW'(width_r);
    end
    if (height_r == '0) begin
      eff_h = HW'(1);
    end else if (height_r > HW'(bblur_pkg::MAX_HEIGHT)) begin
      eff_h = HW'(bblur_pkg::MAX_HEIGHT);
    end else begin
      eff_h = height_r;
    end
  end

  // ---------------- position decode ----------------
  assign in_col_last  = (EWW'(in_col_r) + EWW'(1)) >= eff_w;
  assign in_row_last  = (HW'(in_row_r) + HW'(1)) >= eff_h;
  assign in_col_next  = in_col_last ? '0 : in_col_r + CW'(1);
  assign ready_in     = (in_row_r > RW'(1)) || ((in_row_r != '0) && (in_col_r != '0));
  assign h_one        = (eff_h == HW'(1));
  assign out_col_last = (EWW'(out_col_r) + EWW'(1)) >= eff_w;
  assign out_row_last = (HW'(out_row_r) + HW'(1)) >= eff_h;
  assign out_last     = out_col_last && out_row_last;

  assign rd_idle  = !extra_r && (cmd_r == bblur_pkg::CMD_FLUSH) && !draining_r;
  assign rd_drop  = !extra_r && (cmd_r == bblur_pkg::CMD_PIXEL) && draining_r;
  assign rd_flush = !extra_r && (cmd_r == bblur_pkg::CMD_FLUSH) && draining_r;
  assign rd_pix   = !extra_r && (cmd_r == bblur_pkg::CMD_PIXEL) && !draining_r;
  // one-row frame: the last pixel pushes one more empty column
  assign last_one_row = rd_pix && in_col_last && in_row_last && h_one;

  assign out_free = !out_valid_r || out_ch.ready;

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bblur_pkg::S_IDLE: begin
        if (accept) state_nxt = bblur_pkg::S_READ;
      end
      bblur_pkg::S_READ: begin
        if (extra_r) begin
          state_nxt = pend_r ? bblur_pkg::S_COL : bblur_pkg::S_IDLE;
        end else if (rd_idle) begin
          state_nxt = bblur_pkg::S_IDLE;
        end else if (rd_drop) begin
          state_nxt = bblur_pkg::S_EMIT;
        end else if (rd_flush) begin
          state_nxt = bblur_pkg::S_COL;
        end else if (last_one_row) begin
          state_nxt = bblur_pkg::S_PUSH2;
        end else begin
          state_nxt = ready_in ? bblur_pkg::S_COL : bblur_pkg::S_IDLE;
        end
      end
      bblur_pkg::S_PUSH2: state_nxt = bblur_pkg::S_READ;
      bblur_pkg::S_COL:   state_nxt = bblur_pkg::S_TOT;
      bblur_pkg::S_TOT:   state_nxt = bblur_pkg::S_MUL;
      bblur_pkg::S_MUL:   state_nxt = bblur_pkg::S_EMIT;
      bblur_pkg::S_EMIT: begin
        if (out_free) state_nxt = bblur_pkg::S_IDLE;
      end
      default: state_nxt = bblur_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == bblur_pkg::S_IDLE);
    do_push   = (state_r == bblur_pkg::S_READ) && (extra_r || rd_flush || rd_pix);
    pix_adv   = (state_r == bblur_pkg::S_READ) && rd_pix;
    mem_re    = (in_ready && in_ch.valid) || (state_r == bblur_pkg::S_PUSH2);
    ld_col    = (state_r == bblur_pkg::S_COL);
    ld_tot    = (state_r == bblur_pkg::S_TOT);
    ld_mul    = (state_r == bblur_pkg::S_MUL);
    emit_fire = (state_r == bblur_pkg::S_EMIT) && out_free;
  end

  assign accept      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;
  assign restart     = cfg_we || (emit_fire && !drop_r && out_last);

  // ---------------- line memory ----------------
  assign rd_above = rd_q[2*PW-1:PW];
  assign rd_cur   = rd_q[PW-1:0];
  assign push_px  = (extra_r || (cmd_r == bblur_pkg::CMD_FLUSH)) ? '0 : px_r;

  // write in the read state, reads only issued in later cycles: no overlap
  always_ff @(posedge clk) begin
    if (do_push) line_mem[in_col_r] <= {rd_cur, push_px};
    if (mem_re)  rd_q <= line_mem[in_col_r];
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= bblur_pkg::S_IDLE;
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      draining_r <= 1'b0;
      extra_r    <= 1'b0;
      pend_r     <= 1'b0;
      drop_r     <= 1'b0;
      for (int k = 0; k < 3; k++) win_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        extra_r <= 1'b0;
        drop_r  <= 1'b0;
      end
      if (state_r == bblur_pkg::S_PUSH2) extra_r <= 1'b1;
      if ((state_r == bblur_pkg::S_READ) && !extra_r) drop_r <= rd_drop;
      if (pix_adv) pend_r <= ready_in;
      if (do_push) begin
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
        win_r[2] <= {rd_above, rd_cur, push_px};
        in_col_r <= in_col_next;
      end
      if (pix_adv && in_col_last) begin
        if (in_row_last) begin
          draining_r <= 1'b1;
        end else begin
          in_row_r <= in_row_r + RW'(1);
        end
      end
      if (emit_fire && !drop_r && !out_last) begin
        if (out_col_last) begin
          out_col_r <= '0;
          out_row_r <= out_row_r + RW'(1);
        end else begin
          out_col_r <= out_col_r + CW'(1);
        end
      end
      if (restart) begin
        in_col_r   <= '0;
        in_row_r   <= '0;
        out_col_r  <= '0;
        out_row_r  <= '0;
        draining_r <= 1'b0;
        for (int k = 0; k < 3; k++) win_r[k] <= '0;
      end
    end
  end

  // ---------------- neighbourhood sum and mean ----------------
  always_comb begin
    logic rv0, rv2, cv0, cv2;
    logic [1:0] nrows, ncols;
    rv0 = (out_row_r != '0);
    rv2 = !out_row_last;
    cv0 = (out_col_r != '0);
    cv2 = !out_col_last;
    for (int k = 0; k < 3; k++) begin
      colsum[k] = (rv0 ? bblur_pkg::COLSUM_W'(win_r[k][3*PW-1:2*PW]) : '0)
                + bblur_pkg::COLSUM_W'(win_r[k][2*PW-1:PW])
                + (rv2 ? bblur_pkg::COLSUM_W'(win_r[k][PW-1:0]) : '0);
    end
    if (!cv0) colsum[0] = '0;
    if (!cv2) colsum[2] = '0;
    nrows = 2'd1 + 2'(rv0) + 2'(rv2);
    ncols = 2'd1 + 2'(cv0) + 2'(cv2);
    cnt   = bblur_pkg::CNT_W'(nrows) * bblur_pkg::CNT_W'(ncols);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_ch.command;
      px_r  <= in_ch.pixel_in;
    end
    if (ld_col) begin
      for (int k = 0; k < 3; k++) colsum_r[k] <= colsum[k];
      cnt_r <= cnt;
    end
    if (ld_tot) begin
      sum_r   <= bblur_pkg::SUM_W'(colsum_r[0]) + bblur_pkg::SUM_W'(colsum_r[1])
               + bblur_pkg::SUM_W'(colsum_r[2]);
      recip_r <= bblur_pkg::recip(cnt_r);
    end
    if (ld_mul) prod_r <= bblur_pkg::PROD_W'(sum_r) * bblur_pkg::PROD_W'(recip_r);
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      if (drop_r) begin
        out_pix_r  <= '0;
        out_eof_r  <= 1'b0;
        out_drop_r <= 1'b1;
      end else begin
        out_pix_r  <= prod_r[bblur_pkg::RECIP_SHIFT +: PW];
        out_eof_r  <= out_last;
        out_drop_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_out    = out_pix_r;
  assign out_ch.end_of_frame = out_eof_r;
  assign out_ch.dropped      = out_drop_r;

endmodule

>>> src/bblur_chk.sv
// Port-level checks for the box blur top level, and the bind that attaches them.
// Depends on bblur_pkg and on the top level's ports.
module bblur_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bblur_pkg::PIX_W-1:0] out_pixel,
  input logic                        out_eof,
  input logic                        out_drop
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_pixel)
      && $stable(out_eof) && $stable(out_drop)))
    else $error("result changed while stalled");

  // one transaction at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while previous transaction in progress");

  // a fresh result never appears straight after an acceptance
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result appeared too soon after acceptance");

  // a dropped pixel carries a zero grey level and no frame end
  a_drop_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_drop) |-> ((out_pixel == '0) && !out_eof))
    else $error("dropped result carries data");

endmodule

bind box_blur_3x3_edge_normalized bblur_chk u_bblur_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_pixel (out_ch.pixel_out),
  .out_eof   (out_ch.end_of_frame),
  .out_drop  (out_ch.dropped)
);

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for box_blur_3x3_edge_normalized: directed frames, random frames,
// then the register extremes, each result checked against an in-bench blur predictor.
// Depends on bblur_pkg, the bblur_in_if / bblur_out_if interfaces and the block itself.
module testbench;

  localparam int PIX_W         = bblur_pkg::PIX_W;
  localparam int CFG_W_W       = bblur_pkg::CFG_W_W;
  localparam int CFG_H_W       = bblur_pkg::CFG_H_W;
  localparam int MAX_WIDTH_DEF = bblur_pkg::MAX_WIDTH_DEF;
  localparam int MAX_HEIGHT    = bblur_pkg::MAX_HEIGHT;
  localparam int RESET_WIDTH   = bblur_pkg::RESET_WIDTH;
  localparam int RESET_HEIGHT  = bblur_pkg::RESET_HEIGHT;
  localparam int APB_AW        = bblur_pkg::APB_AW;
  localparam int APB_DW        = bblur_pkg::APB_DW;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 6;
  localparam int QUIET_CYCLES = 16;
  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             eof;
    logic             drop;
  } blur_res_t;

  // predicts every blurred pixel and checks the output stream against it
  class blur_tracker;
    logic [CFG_W_W-1:0] width_reg;
    logic [CFG_H_W-1:0] height_reg;
    logic [PIX_W-1:0]   upper_line [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]   lower_line [MAX_WIDTH_DEF];
    logic [23:0]        win [3];
    int unsigned        in_x, in_y, out_x, out_y;
    bit                 draining;
    blur_res_t          pending_blurs[$];
    int unsigned        errors, blurred, refused, frames, reg_writes;

    function new();
      width_reg  = CFG_W_W'(RESET_WIDTH);
      height_reg = CFG_H_W'(RESET_HEIGHT);
      for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
      end
      restart();
    endfunction

    function int unsigned cols();
      int unsigned w;
      w = width_reg;
      if (w == 0) w = 1;
      if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
      return w;
    endfunction

    function int unsigned rows();
      int unsigned h;
      h = height_reg;
      if (h == 0) h = 1;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      return h;
    endfunction

    function void restart();
      in_x = 0;
      in_y = 0;
      out_x = 0;
      out_y = 0;
      for (int k = 0; k < 3; k++) win[k] = '0;
      draining = 1'b0;
    endfunction

    // new column triplet: two rows from the line stores plus the incoming pixel
    function void shift_in(logic [PIX_W-1:0] px);
      int unsigned c;
      logic [PIX_W-1:0] a, b;
      c = (in_x >= MAX_WIDTH_DEF) ? 0 : in_x;
      a = upper_line[c];
      b = lower_line[c];
      upper_line[c] = b;
      lower_line[c] = px;
      win[0] = win[1];
      win[1] = win[2];
      win[2] = {a, b, px};
      in_x++;
      if (in_x >= cols()) in_x = 0;
    endfunction

    function blur_res_t mean_next();
      int unsigned w, h, sum, cnt;
      bit last;
      blur_res_t r;
      w = cols();
      h = rows();
      sum = 0;
      cnt = 0;
      for (int unsigned k = 0; k < 3; k++) begin
        if (k == 0 && out_x < 1) continue;
        if (k == 2 && out_x + 1 >= w) continue;
        for (int unsigned rr = 0; rr < 3; rr++) begin
          if (rr == 0 && out_y < 1) continue;
          if (rr == 2 && out_y + 1 >= h) continue;
          sum += win[k][8*(2-rr) +: 8];
          cnt++;
        end
      end
      if (cnt == 0) cnt = 1;
      last = (out_x + 1 >= w) && (out_y + 1 >= h);
      r.pix  = PIX_W'(sum / cnt);
      r.eof  = last;
      r.drop = 1'b0;
      if (last) begin
        restart();
      end else begin
        out_x++;
        if (out_x >= w) begin
          out_x = 0;
          out_y++;
        end
      end
      return r;
    endfunction

    function void note_item(bblur_pkg::cmd_t cmd, logic [PIX_W-1:0] px);
      int unsigned w, h, ix, iy;
      bit ready_out;
      blur_res_t r;
      w = cols();
      h = rows();
      if (cmd == bblur_pkg::CMD_FLUSH) begin
        if (draining) begin
          shift_in('0);
          pending_blurs.push_back(mean_next());
        end
        return;
      end
      // frame still draining: the pixel is refused
      if (draining) begin
        r = '0;
        r.drop = 1'b1;
        pending_blurs.push_back(r);
        return;
      end
      ix = in_x;
      iy = in_y;
      ready_out = (iy >= 2) || (iy >= 1 && ix >= 1);
      shift_in(px);
      if (ix + 1 >= w) begin
        if (iy + 1 >= h) begin
          draining = 1'b1;
          in_x = 0;
          // one-row frame: an empty column so every flush yields an output
          if (h == 1) shift_in('0);
        end else begin
          in_y++;
        end
      end
      if (ready_out) pending_blurs.push_back(mean_next());
    endfunction

    function void set_register(bblur_pkg::reg_idx_t idx, logic [APB_DW-1:0] value);
      if (idx == bblur_pkg::REG_WIDTH) width_reg = value[CFG_W_W-1:0];
      else height_reg = value[CFG_H_W-1:0];
      reg_writes++;
      restart();
    endfunction

    function void check_output(logic [PIX_W-1:0] pix, logic eof, logic drop);
      blur_res_t e;
      if (pending_blurs.size() == 0) begin
        $display("%0t: unexpected output pixel_out=%0d end_of_frame=%0b dropped=%0b",
                 $time, pix, eof, drop);
        errors++;
        return;
      end
      e = pending_blurs.pop_front();
      if (pix !== e.pix) begin
        $display("%0t: pixel_out expected %0d got %0d", $time, e.pix, pix);
        errors++;
      end
      if (eof !== e.eof) begin
        $display("%0t: end_of_frame expected %0b got %0b", $time, e.eof, eof);
        errors++;
      end
      if (drop !== e.drop) begin
        $display("%0t: dropped expected %0b got %0b", $time, e.drop, drop);
        errors++;
      end
      if (e.drop) refused++;
      else blurred++;
      if (e.eof) frames++;
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                psel, penable, pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  bblur_in_if  in_ch();
  bblur_out_if out_ch();

  blur_tracker tracker;
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned accepted_items;
  int unsigned cycle_count;

  box_blur_3x3_edge_normalized DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("testbench: FAIL");
    $finish;
  end

  // result side: random back-pressure, every accepted transaction checked
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        tracker.check_output(out_ch.pixel_out, out_ch.end_of_frame, out_ch.dropped);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [PIX_W-1:0] pick_pixel();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PIX_W'($urandom_range(255));
  endfunction

  task automatic push_item(bblur_pkg::cmd_t cmd, logic [PIX_W-1:0] px);
    bit ignored;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.pixel_in <= px;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ignored = (cmd == bblur_pkg::CMD_FLUSH) && !tracker.draining;
    tracker.note_item(cmd, px);
    if (!ignored) accepted_items++;
  endtask

  // all results in, then room for an item still in flight that gives none
  task automatic drain_and_wait();
    in_ch.valid <= 1'b0;
    while (tracker.pending_blurs.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(bblur_pkg::reg_idx_t idx, logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_register(idx, value);
    @(posedge clk);
  endtask

  task automatic configure(int unsigned w, int unsigned h);
    drain_and_wait();
    write_reg(bblur_pkg::REG_WIDTH, APB_DW'(w));
    write_reg(bblur_pkg::REG_HEIGHT, APB_DW'(h));
  endtask

  task automatic flush_frame(bit noisy);
    while (tracker.draining) begin
      if (noisy && $urandom_range(99) < 6) push_item(bblur_pkg::CMD_PIXEL, pick_pixel());
      else push_item(bblur_pkg::CMD_FLUSH, pick_pixel());
    end
  endtask

  task automatic run_frame(bit noisy, bit may_abort, output bit aborted);
    int unsigned total, npix;
    total = tracker.cols() * tracker.rows();
    npix = total;
    aborted = 1'b0;
    if (may_abort && total > 1 && $urandom_range(99) < 8) begin
      npix = $urandom_range(total - 1, 1);
      aborted = 1'b1;
    end
    for (int unsigned i = 0; i < npix; i++) begin
      if (noisy && $urandom_range(99) < 3) push_item(bblur_pkg::CMD_FLUSH, pick_pixel());
      push_item(bblur_pkg::CMD_PIXEL, pick_pixel());
    end
    if (!aborted) flush_frame(noisy);
  endtask

  initial begin
    logic [PIX_W-1:0] corner_frame [9];
    int unsigned start_items, sel, w, h, nframes;
    bit aborted;

    tracker = new();
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.command  <= bblur_pkg::CMD_PIXEL;
    in_ch.pixel_in <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    send_idle_pct  = 15;
    recv_idle_pct  = 48;
    accepted_items = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // flush with nothing pending gives no output
    push_item(bblur_pkg::CMD_FLUSH, '1);

    // 3x3: corners, edges and the centre, pixels at the extremes
    corner_frame = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF};
    configure(3, 3);
    foreach (corner_frame[i]) push_item(bblur_pkg::CMD_PIXEL, corner_frame[i]);
    push_item(bblur_pkg::CMD_PIXEL, 8'hAA);
    flush_frame(1'b0);
    push_item(bblur_pkg::CMD_FLUSH, 8'h55);

    // single pixel frame, then one column three rows high
    configure(1, 1);
    push_item(bblur_pkg::CMD_PIXEL, 8'hFF);
    flush_frame(1'b0);
    configure(1, 3);
    push_item(bblur_pkg::CMD_PIXEL, 8'hFF);
    push_item(bblur_pkg::CMD_PIXEL, 8'hFF);
    push_item(bblur_pkg::CMD_PIXEL, 8'h01);
    flush_frame(1'b0);

    start_items = accepted_items;
    while (accepted_items - start_items < RANDOM_ITEMS) begin
      if (accepted_items - start_items < RANDOM_ITEMS / 3) begin
        send_idle_pct = 15;
        recv_idle_pct = 48;
      end else if (accepted_items - start_items < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 48;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      sel = $urandom_range(99);
      if (sel < 70) begin
        w = $urandom_range(8, 1);
        h = $urandom_range(6, 1);
      end else if (sel < 88) begin
        w = $urandom_range(40, 9);
        h = $urandom_range(4, 1);
      end else if (sel < 94) begin
        w = $urandom_range(2, 0);
        h = $urandom_range(12, 0);
      end else if (sel < 99) begin
        w = $urandom_range(3, 1);
        h = $urandom_range(60, 20);
      end else begin
        w = $urandom_range(511, 200);
        h = $urandom_range(2, 1);
      end
      configure(w, h);
      nframes = $urandom_range(3, 1);
      aborted = 1'b0;
      for (int unsigned f = 0; f < nframes && !aborted; f++)
        run_frame(1'b1, 1'b1, aborted);
    end

    // register extremes, including values past the clamp
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(511, 1);
    run_frame(1'b0, 1'b0, aborted);
    configure(0, 0);
    run_frame(1'b0, 1'b0, aborted);
    configure(256, 4096);
    repeat (40) push_item(bblur_pkg::CMD_PIXEL, pick_pixel());
    configure(1, 8191);
    repeat (40) push_item(bblur_pkg::CMD_PIXEL, pick_pixel());

    drain_and_wait();
    $display("covered %0d transactions in, %0d blurred and %0d refused pixels out, %0d frames",
             accepted_items, tracker.blurred, tracker.refused, tracker.frames);
    $display("%0d register writes, widths 0 to 511, heights 0 to 8191, %0d mismatches",
             tracker.reg_writes, tracker.errors);
    if (tracker.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
